// ----- hdl/sap_pkg.sv -----
// package: payload types, register indexes and constants of the servo pulse mapper
package sap_pkg;

   localparam int PULSE_W = 12;
   localparam int ANGLE_W = 16;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 16;

   localparam int unsigned PERCENT_FULL = 10000;
   localparam int unsigned MS_PER_S = 1000;
   localparam int unsigned STEP_CAP = 131071;

   localparam logic signed [ANGLE_W-1:0] MIN_ANGLE_RST = -16'sd6434;
   localparam logic signed [ANGLE_W-1:0] MAX_ANGLE_RST = 16'sd6434;
   localparam logic [PULSE_W-1:0] MIN_PULSE_RST = 12'd500;
   localparam logic [PULSE_W-1:0] MAX_PULSE_RST = 12'd2500;
   localparam logic [PULSE_W-1:0] CUR_PULSE_RST = 12'd1500;
   localparam logic [15:0] SLEW_RATE_RST = 16'd4096;

   typedef enum logic [1:0] {
      OP_ANGLE   = 2'd0,
      OP_PERCENT = 2'd1,
      OP_PULSE   = 2'd2,
      OP_NONE    = 2'd3
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MIN_ANGLE = 3'd0,
      CSR_MAX_ANGLE = 3'd1,
      CSR_MIN_PULSE = 3'd2,
      CSR_MAX_PULSE = 3'd3,
      CSR_OFFSET    = 3'd4,
      CSR_SLEW_EN   = 3'd5,
      CSR_SLEW_RATE = 3'd6,
      CSR_SPARE     = 3'd7
   } csr_idx_type;

   typedef struct packed {
      logic [1:0]                opcode;
      logic signed [ANGLE_W-1:0] angle_cmd;
      logic [13:0]               percent_cmd;
      logic [15:0]               pulse_cmd;
      logic [31:0]               now_ms;
   } req_type;

   typedef struct packed {
      logic [PULSE_W-1:0]        pulse_width;
      logic signed [ANGLE_W-1:0] applied_angle;
      logic signed [ANGLE_W-1:0] target_angle;
      logic                      slew_limited;
   } rsp_type;

endpackage

// ----- hdl/servo_angle_to_pulse_slew_top.sv -----
// servo command mapper: angle, percent or raw pulse to pulse width with slew limit
//
// One command is taken at a time; req_ready is high only while the block is
// idle and no result is waiting. The work runs on one shared multiplier and
// one radix-2 restoring divider. A stored command with no pending pulse
// update skips the divider; a raw pulse uses at most one division, an angle
// at most one without and two with slew limiting, a percent command one more.
// Limit register writes clamp the held angle at once; the held pulse is
// recomputed on the next command that needs it.
module servo_angle_to_pulse_slew_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  sap_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output sap_pkg::rsp_type  rsp_data,
   input  logic              csr_we,
   input  logic [2:0]        csr_index,
   input  logic [15:0]       csr_wdata
);
   import sap_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE, ST_PCT_MUL, ST_RAW_CLAMP, ST_RAW_MUL, ST_TARGET, ST_SLEW_MUL,
      ST_A2P_CHK, ST_A2P_MUL, ST_DIV_LOAD, ST_DIV_RUN, ST_DIV_DONE, ST_COMMIT,
      ST_OUT
   } state_type;

   typedef enum logic [1:0] {PH_PCT, PH_SLEW, PH_A2P, PH_RAW} phase_type;

   function automatic logic signed [15:0] clamp19(input logic signed [18:0] v,
                                                  input logic signed [15:0] lo,
                                                  input logic signed [15:0] hi);
      logic signed [15:0] r;
      if (v < 19'(lo)) r = lo;
      else if (v > 19'(hi)) r = hi;
      else r = v[15:0];
      return r;
   endfunction

   function automatic logic signed [15:0] sat16(input logic signed [18:0] v);
      logic signed [15:0] r;
      if (v < -19'sd32768) r = -16'sd32768;
      else if (v > 19'sd32767) r = 16'sd32767;
      else r = v[15:0];
      return r;
   endfunction

   state_type state_ff;
   phase_type phase_ff;

   logic signed [15:0] min_angle_ff, max_angle_ff, offset_ff;
   logic [PULSE_W-1:0] min_pulse_ff, max_pulse_ff;
   logic               slew_en_ff;
   logic [15:0]        rate_ff;

   logic signed [15:0] cur_angle_ff, rec_target_ff;
   logic [31:0]        last_tick_ff;
   logic               has_last_ff, dirty_ff;
   logic [PULSE_W-1:0] cur_pulse_ff;

   req_type            req_ff;
   logic signed [15:0] cmd_ff, target_ff, ang_ff;
   logic [PULSE_W-1:0] pulse_wk_ff;
   logic               slim_ff;
   logic signed [50:0] prod_ff;
   logic signed [17:0] add_ff;
   logic [18:0]        den_ff;
   logic [47:0]        dq_ff;
   logic [18:0]        rem_ff;
   logic               neg_ff;
   logic [5:0]         cnt_ff;
   rsp_type            rsp_ff;
   logic               rsp_valid_ff;

   logic signed [16:0] arange_c;
   logic signed [12:0] prange_c;
   logic signed [17:0] num_c;
   logic [PULSE_W-1:0] raw_n_c;
   logic signed [32:0] mul_a_c;
   logic signed [17:0] mul_b_c;
   logic signed [50:0] prod_c;
   logic signed [51:0] dnum_c, dneg_c;
   logic [19:0]        trial_c;
   logic               ge_c;
   logic signed [48:0] q_c;
   logic signed [17:0] phys_c, delta_c, s_c;
   logic [16:0]        step_c;
   logic signed [18:0] lim_c;
   logic signed [16:0] tsum_c;
   logic [15:0]        raw_p_c;
   logic signed [15:0] new_min_c, new_max_c;

   assign arange_c = 17'(max_angle_ff) - 17'(min_angle_ff);
   assign prange_c = $signed({1'b0, max_pulse_ff}) - $signed({1'b0, min_pulse_ff});
   assign num_c    = 18'(ang_ff) - 18'(min_angle_ff);
   assign raw_n_c  = pulse_wk_ff - min_pulse_ff;
   assign tsum_c   = 17'(cmd_ff) + 17'(offset_ff);

   always_comb begin
      case (state_ff)
         ST_PCT_MUL: begin
            mul_a_c = 33'(arange_c);
            mul_b_c = (req_ff.percent_cmd > 14'(PERCENT_FULL)) ?
                      $signed({3'b0, 14'(PERCENT_FULL), 1'b0}) :
                      $signed({3'b0, req_ff.percent_cmd, 1'b0});
         end
         ST_SLEW_MUL: begin
            mul_a_c = $signed({1'b0, req_ff.now_ms - last_tick_ff});
            mul_b_c = $signed({2'b0, rate_ff});
         end
         ST_A2P_MUL: begin
            mul_a_c = 33'(num_c);
            mul_b_c = $signed({4'b0, prange_c[12:0], 1'b0});
         end
         ST_RAW_MUL: begin
            mul_a_c = 33'(arange_c);
            mul_b_c = $signed({5'b0, raw_n_c, 1'b0});
         end
         default: begin
            mul_a_c = '0;
            mul_b_c = '0;
         end
      endcase
   end

   assign prod_c  = mul_a_c * mul_b_c;
   assign dnum_c  = 52'(prod_ff) + 52'(add_ff);
   assign dneg_c  = -dnum_c + $signed({33'b0, den_ff}) - 52'sd1;
   assign trial_c = {rem_ff, dq_ff[47]};
   assign ge_c    = trial_c >= {1'b0, den_ff};
   assign q_c     = neg_ff ? -$signed({1'b0, dq_ff}) : $signed({1'b0, dq_ff});
   assign phys_c  = 18'(min_angle_ff) + $signed(q_c[17:0]);
   assign step_c  = (dq_ff > 48'(STEP_CAP)) ? 17'(STEP_CAP) : dq_ff[16:0];
   assign s_c     = $signed({1'b0, step_c});
   assign delta_c = 18'(target_ff) - 18'(cur_angle_ff);

   always_comb begin
      if (step_c == '0) lim_c = 19'(cur_angle_ff);
      else if (delta_c > s_c) lim_c = 19'(cur_angle_ff) + 19'(s_c);
      else if (delta_c < -s_c) lim_c = 19'(cur_angle_ff) - 19'(s_c);
      else lim_c = 19'(target_ff);
   end

   always_comb begin
      raw_p_c = req_ff.pulse_cmd;
      if (max_pulse_ff <= min_pulse_ff) raw_p_c = 16'(min_pulse_ff);
      else if (req_ff.pulse_cmd < 16'(min_pulse_ff)) raw_p_c = 16'(min_pulse_ff);
      else if (req_ff.pulse_cmd > 16'(max_pulse_ff)) raw_p_c = 16'(max_pulse_ff);
   end

   assign new_min_c = (csr_index == CSR_MIN_ANGLE) ? $signed(csr_wdata) : min_angle_ff;
   assign new_max_c = (csr_index == CSR_MAX_ANGLE) ? $signed(csr_wdata) : max_angle_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         phase_ff      <= PH_PCT;
         min_angle_ff  <= MIN_ANGLE_RST;
         max_angle_ff  <= MAX_ANGLE_RST;
         min_pulse_ff  <= MIN_PULSE_RST;
         max_pulse_ff  <= MAX_PULSE_RST;
         offset_ff     <= '0;
         slew_en_ff    <= 1'b0;
         rate_ff       <= SLEW_RATE_RST;
         cur_angle_ff  <= '0;
         rec_target_ff <= '0;
         last_tick_ff  <= '0;
         has_last_ff   <= 1'b0;
         dirty_ff      <= 1'b0;
         cur_pulse_ff  <= CUR_PULSE_RST;
         rsp_valid_ff  <= 1'b0;
         cnt_ff        <= '0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  req_ff <= req_data;
                  cmd_ff <= req_data.angle_cmd;
                  case (op_type'(req_data.opcode))
                     OP_ANGLE: state_ff <= ST_TARGET;
                     OP_PERCENT: state_ff <= ST_PCT_MUL;
                     OP_PULSE: state_ff <= ST_RAW_CLAMP;
                     default: begin
                        ang_ff      <= cur_angle_ff;
                        pulse_wk_ff <= cur_pulse_ff;
                        state_ff    <= dirty_ff ? ST_A2P_CHK : ST_COMMIT;
                     end
                  endcase
               end
            end
            ST_PCT_MUL: begin
               prod_ff  <= prod_c;
               add_ff   <= 18'(PERCENT_FULL);
               den_ff   <= 19'(2 * PERCENT_FULL);
               phase_ff <= PH_PCT;
               state_ff <= ST_DIV_LOAD;
            end
            ST_RAW_CLAMP: begin
               pulse_wk_ff <= raw_p_c[PULSE_W-1:0];
               ang_ff      <= min_angle_ff;
               state_ff    <= (prange_c <= 0) ? ST_COMMIT : ST_RAW_MUL;
            end
            ST_RAW_MUL: begin
               prod_ff  <= prod_c;
               add_ff   <= 18'(prange_c);
               den_ff   <= {5'b0, prange_c[12:0], 1'b0};
               phase_ff <= PH_RAW;
               state_ff <= ST_DIV_LOAD;
            end
            ST_TARGET: begin
               target_ff <= clamp19(19'(tsum_c), min_angle_ff, max_angle_ff);
               ang_ff    <= clamp19(19'(tsum_c), min_angle_ff, max_angle_ff);
               slim_ff   <= 1'b0;
               state_ff  <= (slew_en_ff && has_last_ff) ? ST_SLEW_MUL : ST_A2P_CHK;
            end
            ST_SLEW_MUL: begin
               prod_ff  <= prod_c;
               add_ff   <= '0;
               den_ff   <= 19'(MS_PER_S);
               phase_ff <= PH_SLEW;
               state_ff <= ST_DIV_LOAD;
            end
            ST_A2P_CHK: begin
               if (arange_c <= 0 || prange_c <= 0 || num_c <= 0) begin
                  pulse_wk_ff <= min_pulse_ff;
                  state_ff    <= ST_COMMIT;
               end else if (num_c >= 18'(arange_c)) begin
                  pulse_wk_ff <= max_pulse_ff;
                  state_ff    <= ST_COMMIT;
               end else begin
                  state_ff <= ST_A2P_MUL;
               end
            end
            ST_A2P_MUL: begin
               prod_ff  <= prod_c;
               add_ff   <= 18'(arange_c);
               den_ff   <= {1'b0, arange_c[16:0], 1'b0};
               phase_ff <= PH_A2P;
               state_ff <= ST_DIV_LOAD;
            end
            ST_DIV_LOAD: begin
               neg_ff   <= dnum_c[51];
               dq_ff    <= dnum_c[51] ? dneg_c[47:0] : dnum_c[47:0];
               rem_ff   <= '0;
               cnt_ff   <= '0;
               state_ff <= ST_DIV_RUN;
            end
            ST_DIV_RUN: begin
               rem_ff <= ge_c ? 19'(trial_c - {1'b0, den_ff}) : trial_c[18:0];
               dq_ff  <= {dq_ff[46:0], ge_c};
               cnt_ff <= cnt_ff + 6'd1;
               if (cnt_ff == 6'd47) state_ff <= ST_DIV_DONE;
            end
            ST_DIV_DONE: begin
               case (phase_ff)
                  PH_PCT: begin
                     cmd_ff   <= sat16(19'(phys_c) - 19'(offset_ff));
                     state_ff <= ST_TARGET;
                  end
                  PH_SLEW: begin
                     ang_ff   <= clamp19(lim_c, min_angle_ff, max_angle_ff);
                     slim_ff  <= clamp19(lim_c, min_angle_ff, max_angle_ff) != target_ff;
                     state_ff <= ST_A2P_CHK;
                  end
                  PH_A2P: begin
                     pulse_wk_ff <= min_pulse_ff + q_c[PULSE_W-1:0];
                     state_ff    <= ST_COMMIT;
                  end
                  default: begin
                     ang_ff   <= min_angle_ff + q_c[15:0];
                     state_ff <= ST_COMMIT;
                  end
               endcase
            end
            ST_COMMIT: begin
               cur_pulse_ff <= pulse_wk_ff;
               dirty_ff     <= 1'b0;
               rsp_valid_ff <= 1'b1;
               rsp_ff.pulse_width <= pulse_wk_ff;
               case (op_type'(req_ff.opcode))
                  OP_ANGLE, OP_PERCENT: begin
                     cur_angle_ff  <= ang_ff;
                     rec_target_ff <= cmd_ff;
                     last_tick_ff  <= req_ff.now_ms;
                     has_last_ff   <= 1'b1;
                     rsp_ff.applied_angle <= ang_ff;
                     rsp_ff.target_angle  <= cmd_ff;
                     rsp_ff.slew_limited  <= slim_ff;
                  end
                  OP_PULSE: begin
                     cur_angle_ff  <= ang_ff;
                     rec_target_ff <= sat16(19'(ang_ff) - 19'(offset_ff));
                     last_tick_ff  <= req_ff.now_ms;
                     has_last_ff   <= 1'b1;
                     rsp_ff.applied_angle <= ang_ff;
                     rsp_ff.target_angle  <= sat16(19'(ang_ff) - 19'(offset_ff));
                     rsp_ff.slew_limited  <= 1'b0;
                  end
                  default: begin
                     rsp_ff.applied_angle <= cur_angle_ff;
                     rsp_ff.target_angle  <= rec_target_ff;
                     rsp_ff.slew_limited  <= 1'b0;
                  end
               endcase
               state_ff <= ST_OUT;
            end
            ST_OUT: begin
               if (rsp_ready) begin
                  rsp_valid_ff <= 1'b0;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase

         if (csr_we) begin
            case (csr_idx_type'(csr_index))
               CSR_MIN_ANGLE, CSR_MAX_ANGLE, CSR_MIN_PULSE, CSR_MAX_PULSE: begin
                  if (csr_index == CSR_MIN_ANGLE) min_angle_ff <= $signed(csr_wdata);
                  if (csr_index == CSR_MAX_ANGLE) max_angle_ff <= $signed(csr_wdata);
                  if (csr_index == CSR_MIN_PULSE) min_pulse_ff <= csr_wdata[PULSE_W-1:0];
                  if (csr_index == CSR_MAX_PULSE) max_pulse_ff <= csr_wdata[PULSE_W-1:0];
                  cur_angle_ff <= clamp19(19'(cur_angle_ff), new_min_c, new_max_c);
                  dirty_ff     <= 1'b1;
               end
               CSR_OFFSET: offset_ff <= $signed(csr_wdata);
               CSR_SLEW_EN: begin
                  slew_en_ff  <= csr_wdata[0];
                  has_last_ff <= 1'b0;
               end
               CSR_SLEW_RATE: begin
                  rate_ff     <= csr_wdata;
                  has_last_ff <= 1'b0;
               end
               default: ;
            endcase
         end
      end
   end

   assign req_ready = state_ff == ST_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ----- hdl/sap_check.sv -----
// port checker for the servo pulse mapper, bound to the top level
module sap_check (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input sap_pkg::rsp_type rsp_data
);
   import sap_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed before transfer");

   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("ready after request transfer");

   a_no_req_while_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("ready while result pending");

   a_no_instant_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !rsp_valid)
      else $error("result in cycle after request");

endmodule

bind servo_angle_to_pulse_slew_top sap_check u_sap_check (.*);

// ----- sim/tb_top.sv -----
// testbench: servo angle to pulse mapper with slew limit, checked against a local predictor
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import sap_pkg::*;

   localparam int IDLE_LIMIT = 5000;
   localparam int LONG_HOLD = 400;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic csr_we = 1'b0;
   logic [2:0] csr_index = '0;
   logic [15:0] csr_wdata = '0;

   servo_angle_to_pulse_slew_top DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #10 clock = ~clock;

   // predictor state and register copies
   int lo_ang, hi_ang, trim;
   int unsigned lo_pls, hi_pls, rate;
   bit slew_on;
   int held_ang;
   bit [31:0] prev_tick;
   bit tick_valid;
   int unsigned held_pls;
   int cmd_rec;

   rsp_type pulse_q[$];
   int fails = 0;
   int idle_cycles = 0;
   int stall_mode = 0;
   int hold_reqs = 0;
   int hold_done = 0;
   int hold_left = 0;
   int rx_cycle = 0;
   int burst_left = 0;
   int gap_max = 3;
   bit [31:0] tick = 0;

   function automatic int sat16(int v);
      if (v < -32768) return -32768;
      if (v > 32767) return 32767;
      return v;
   endfunction

   function automatic int clamp_ang(int v);
      if (v < lo_ang) return lo_ang;
      if (v > hi_ang) return hi_ang;
      return v;
   endfunction

   function automatic longint floor_quot(longint n, longint d);
      longint q;
      q = n / d;
      if ((n % d != 0) && (n < 0)) q--;
      return q;
   endfunction

   function automatic int unsigned ang_to_pls(int a);
      longint ar, pr, num;
      ar = longint'(hi_ang) - longint'(lo_ang);
      pr = longint'(hi_pls) - longint'(lo_pls);
      num = longint'(a) - longint'(lo_ang);
      if (ar <= 0 || pr <= 0 || num <= 0) return lo_pls;
      if (num >= ar) return hi_pls;
      return lo_pls + int'((2 * num * pr + ar) / (2 * ar));
   endfunction

   function automatic int pls_to_ang(int unsigned p);
      longint ar, pr, n;
      pr = longint'(hi_pls) - longint'(lo_pls);
      ar = longint'(hi_ang) - longint'(lo_ang);
      n = longint'(p) - longint'(lo_pls);
      if (pr <= 0) return lo_ang;
      return int'(longint'(lo_ang) + floor_quot(2 * n * ar + pr, 2 * pr));
   endfunction

   function automatic rsp_type pack_rsp(bit lim);
      rsp_type r;
      r.pulse_width = held_pls[PULSE_W-1:0];
      r.applied_angle = held_ang[15:0];
      r.target_angle = cmd_rec[15:0];
      r.slew_limited = lim;
      return r;
   endfunction

   function automatic rsp_type steer(int cmd, bit [31:0] now);
      int tgt, lim, delta, s;
      bit active;
      bit [31:0] dt;
      longint unsigned st;
      tgt = clamp_ang(cmd + trim);
      lim = tgt;
      active = slew_on && tick_valid;
      if (active) begin
         dt = now - prev_tick;
         st = (longint'(rate) * longint'(dt)) / MS_PER_S;
         if (st > STEP_CAP) st = STEP_CAP;
         s = int'(st);
         delta = tgt - held_ang;
         if (s == 0) lim = held_ang;
         else if (delta > s) lim = held_ang + s;
         else if (delta < -s) lim = held_ang - s;
         lim = clamp_ang(lim);
      end
      cmd_rec = cmd;
      held_ang = lim;
      held_pls = ang_to_pls(lim);
      prev_tick = now;
      tick_valid = 1'b1;
      return pack_rsp(active && (lim != tgt));
   endfunction

   function automatic rsp_type predict_pulse(req_type r);
      longint pct, ar;
      int phys;
      int unsigned p;
      case (op_type'(r.opcode))
         OP_ANGLE: return steer(int'(r.angle_cmd), r.now_ms);
         OP_PERCENT: begin
            pct = longint'(r.percent_cmd);
            if (pct > PERCENT_FULL) pct = PERCENT_FULL;
            ar = longint'(hi_ang) - longint'(lo_ang);
            phys = int'(longint'(lo_ang)
                        + floor_quot(2 * pct * ar + PERCENT_FULL, 2 * PERCENT_FULL));
            return steer(sat16(phys - trim), r.now_ms);
         end
         OP_PULSE: begin
            p = r.pulse_cmd;
            if (hi_pls <= lo_pls) p = lo_pls;
            else if (p < lo_pls) p = lo_pls;
            else if (p > hi_pls) p = hi_pls;
            held_pls = p;
            held_ang = pls_to_ang(p);
            cmd_rec = sat16(held_ang - trim);
            prev_tick = r.now_ms;
            tick_valid = 1'b1;
            return pack_rsp(1'b0);
         end
         default: return pack_rsp(1'b0);
      endcase
   endfunction

   function automatic void reg_apply(csr_idx_type idx, logic [15:0] d);
      case (idx)
         CSR_MIN_ANGLE: lo_ang = int'($signed(d));
         CSR_MAX_ANGLE: hi_ang = int'($signed(d));
         CSR_MIN_PULSE: lo_pls = d[PULSE_W-1:0];
         CSR_MAX_PULSE: hi_pls = d[PULSE_W-1:0];
         CSR_OFFSET: trim = int'($signed(d));
         CSR_SLEW_EN: begin slew_on = d[0]; tick_valid = 1'b0; end
         CSR_SLEW_RATE: begin rate = d; tick_valid = 1'b0; end
         default: ;
      endcase
      if (idx <= CSR_MAX_PULSE) begin
         held_ang = clamp_ang(held_ang);
         held_pls = ang_to_pls(held_ang);
      end
   endfunction

   function automatic void predictor_reset();
      lo_ang = int'(MIN_ANGLE_RST);
      hi_ang = int'(MAX_ANGLE_RST);
      lo_pls = MIN_PULSE_RST;
      hi_pls = MAX_PULSE_RST;
      trim = 0;
      slew_on = 1'b0;
      rate = SLEW_RATE_RST;
      held_ang = 0;
      prev_tick = 0;
      tick_valid = 1'b0;
      held_pls = CUR_PULSE_RST;
      cmd_rec = 0;
   endfunction

   task automatic csr_write(csr_idx_type idx, logic [15:0] d);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= d;
      @(posedge clock);
      reg_apply(idx, d);
   endtask

   task automatic wait_drained();
      while (pulse_q.size() != 0) @(posedge clock);
      repeat (5) @(posedge clock);
   endtask

   // one transfer on the command channel, typed expectation used when given
   task automatic send(req_type r, bit typed, rsp_type exp_rsp);
      int gap;
      rsp_type pred;
      if (burst_left == 0) begin
         gap = $urandom_range(0, gap_max);
         burst_left = $urandom_range(1, 12);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (!req_ready);
      pred = predict_pulse(r);
      pulse_q.push_back(typed ? exp_rsp : pred);
   endtask

   function automatic req_type mk_req(op_type op, int ang, int pct, int pls, bit [31:0] now);
      req_type r;
      r.opcode = op;
      r.angle_cmd = ang[15:0];
      r.percent_cmd = pct[13:0];
      r.pulse_cmd = pls[15:0];
      r.now_ms = now;
      return r;
   endfunction

   function automatic rsp_type mk_rsp(int pls, int ang, int tgt);
      rsp_type r;
      r.pulse_width = pls[PULSE_W-1:0];
      r.applied_angle = ang[15:0];
      r.target_angle = tgt[15:0];
      r.slew_limited = 1'b0;
      return r;
   endfunction

   typedef struct {
      bit is_csr;
      csr_idx_type idx;
      logic [15:0] val;
      req_type cmd;
      bit typed;
      rsp_type exp_rsp;
   } step_row;

   step_row steps[$];

   function automatic void add_cmd(req_type r, bit typed = 0, rsp_type e = '0);
      step_row s;
      s.is_csr = 0; s.idx = CSR_SPARE; s.val = '0;
      s.cmd = r; s.typed = typed; s.exp_rsp = e;
      steps.push_back(s);
   endfunction

   function automatic void add_csr(csr_idx_type idx, int v);
      step_row s;
      s.is_csr = 1; s.idx = idx; s.val = v[15:0];
      s.cmd = '0; s.typed = 0; s.exp_rsp = '0;
      steps.push_back(s);
   endfunction

   function automatic req_type rand_req();
      op_type op;
      int sel, ang, pct, pls;
      bit [31:0] dt;
      sel = $urandom_range(0, 9);
      op = (sel < 5) ? OP_ANGLE : (sel < 7) ? OP_PERCENT : (sel < 9) ? OP_PULSE : OP_NONE;
      sel = $urandom_range(0, 9);
      if (sel < 6) ang = sat16(held_ang - trim + $urandom_range(0, 6000) - 3000);
      else if (sel < 8) ang = $urandom_range(0, 65535) - 32768;
      else ang = sat16(($urandom_range(0, 1) ? hi_ang : lo_ang) - trim);
      pct = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 16383) : $urandom_range(0, 10000);
      if ($urandom_range(0, 4) == 0) pls = $urandom_range(0, 65535);
      else pls = $urandom_range(0, 4195);
      sel = $urandom_range(0, 9);
      if (sel == 0) dt = 0;
      else if (sel < 7) dt = $urandom_range(1, 50);
      else if (sel < 9) dt = $urandom_range(50, 5000);
      else dt = $urandom;
      tick = tick + dt;
      return mk_req(op, ang, pct, pls, tick);
   endfunction

   task automatic write_settings(int flavour);
      logic [15:0] v[7];
      case (flavour)
         0: begin
            v[0] = -$urandom_range(1, 20000); v[1] = $urandom_range(1, 20000);
            v[2] = $urandom_range(0, 1500); v[3] = $urandom_range(1600, 4095);
            v[4] = $urandom_range(0, 2000) - 1000; v[5] = 1;
            v[6] = $urandom_range(1, 65535);
         end
         1: begin
            v[0] = 16'h8000; v[1] = 16'h7fff; v[2] = 0; v[3] = 4095;
            v[4] = $urandom_range(0, 1) ? 16'h8000 : 16'h7fff; v[5] = 1;
            v[6] = $urandom_range(0, 1) ? 16'hffff : 16'd1;
         end
         2: for (int i = 0; i < 7; i++) v[i] = $urandom;
         default: begin
            v[0] = -$urandom_range(1000, 8000); v[1] = $urandom_range(1000, 8000);
            v[2] = 500; v[3] = 2500; v[4] = 0; v[5] = 1;
            v[6] = $urandom_range(0, 3);
         end
      endcase
      for (int i = 0; i < 7; i++) csr_write(csr_idx_type'(i), v[i]);
      csr_we <= 1'b0;
   endtask

   // result side: check and stall pattern
   always @(posedge clock) begin
      rsp_type e;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pulse_q.size() == 0) begin
               $error("result transfer with nothing expected");
               fails++;
            end else begin
               e = pulse_q.pop_front();
               if (rsp_data.pulse_width !== e.pulse_width) begin
                  $error("pulse_width exp %0d got %0d", e.pulse_width, rsp_data.pulse_width);
                  fails++;
               end
               if (rsp_data.applied_angle !== e.applied_angle) begin
                  $error("applied_angle exp %0d got %0d", e.applied_angle,
                         rsp_data.applied_angle);
                  fails++;
               end
               if (rsp_data.target_angle !== e.target_angle) begin
                  $error("target_angle exp %0d got %0d", e.target_angle,
                         rsp_data.target_angle);
                  fails++;
               end
               if (rsp_data.slew_limited !== e.slew_limited) begin
                  $error("slew_limited exp %0d got %0d", e.slew_limited,
                         rsp_data.slew_limited);
                  fails++;
               end
            end
         end
         rx_cycle++;
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (hold_done != hold_reqs) begin
            hold_done++;
            hold_left = LONG_HOLD;
            rsp_ready <= 1'b0;
         end else begin
            case (stall_mode)
               0: rsp_ready <= 1'b1;
               1: rsp_ready <= ($urandom_range(0, 3) != 0);
               default: rsp_ready <= ((rx_cycle % 7) > 2);
            endcase
         end
      end
   end

   // watchdog on transfers
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > IDLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   initial begin
      predictor_reset();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed rows at reset settings, then slew and range corner cases
      add_cmd(mk_req(OP_NONE, 1234, 77, 999, 5), 1, mk_rsp(1500, 0, 0));
      add_cmd(mk_req(OP_ANGLE, 6434, 0, 0, 10), 1, mk_rsp(2500, 6434, 6434));
      add_cmd(mk_req(OP_ANGLE, -32768, 0, 0, 11), 1, mk_rsp(500, -6434, -32768));
      add_cmd(mk_req(OP_ANGLE, 32767, 0, 0, 12), 1, mk_rsp(2500, 6434, 32767));
      add_cmd(mk_req(OP_PULSE, 0, 0, 65535, 13), 1, mk_rsp(2500, 6434, 6434));
      add_cmd(mk_req(OP_PULSE, 0, 0, 0, 14), 1, mk_rsp(500, -6434, -6434));
      add_cmd(mk_req(OP_PERCENT, 0, 0, 0, 15), 1, mk_rsp(500, -6434, -6434));
      add_cmd(mk_req(OP_PERCENT, 0, 10000, 0, 16), 1, mk_rsp(2500, 6434, 6434));
      add_cmd(mk_req(OP_PERCENT, 0, 16383, 0, 17), 1, mk_rsp(2500, 6434, 6434));
      add_cmd(mk_req(OP_ANGLE, 0, 0, 0, 18), 1, mk_rsp(1500, 0, 0));
      add_cmd(mk_req(OP_PULSE, 0, 0, 1500, 19));
      add_cmd(mk_req(OP_PERCENT, 0, 5000, 0, 20));
      add_csr(CSR_SLEW_EN, 1);
      add_cmd(mk_req(OP_ANGLE, 0, 0, 0, 100));
      add_cmd(mk_req(OP_ANGLE, 6434, 0, 0, 100));
      add_cmd(mk_req(OP_ANGLE, 6434, 0, 0, 600));
      add_cmd(mk_req(OP_ANGLE, -6434, 0, 0, 32'hffff_ff00));
      add_cmd(mk_req(OP_ANGLE, -6434, 0, 0, 32'h0000_0010));
      add_csr(CSR_SLEW_RATE, 0);
      add_cmd(mk_req(OP_ANGLE, 1000, 0, 0, 20));
      add_cmd(mk_req(OP_ANGLE, 3000, 0, 0, 500));
      add_csr(CSR_SLEW_EN, 0);
      add_csr(CSR_MAX_ANGLE, -6434);
      add_cmd(mk_req(OP_ANGLE, 100, 0, 0, 501));
      add_cmd(mk_req(OP_PULSE, 0, 0, 2000, 502));
      add_csr(CSR_MAX_ANGLE, 6434);
      add_csr(CSR_MAX_PULSE, 500);
      add_cmd(mk_req(OP_PULSE, 0, 0, 3000, 503));
      add_cmd(mk_req(OP_ANGLE, 0, 0, 0, 504));
      add_csr(CSR_MAX_PULSE, 2500);
      add_csr(CSR_OFFSET, 32767);
      add_cmd(mk_req(OP_PERCENT, 0, 10000, 0, 505));
      add_cmd(mk_req(OP_PERCENT, 0, 0, 0, 506));
      add_cmd(mk_req(OP_PULSE, 0, 0, 500, 507));

      foreach (steps[i]) begin
         if (steps[i].is_csr) begin
            req_valid <= 1'b0;
            burst_left = 0;
            wait_drained();
            csr_write(steps[i].idx, steps[i].val);
            csr_we <= 1'b0;
         end else begin
            send(steps[i].cmd, steps[i].typed, steps[i].exp_rsp);
         end
      end

      // random phases over several register settings
      for (int ph = 1; ph <= 9; ph++) begin
         req_valid <= 1'b0;
         burst_left = 0;
         wait_drained();
         write_settings(ph % 4);
         stall_mode = $urandom_range(0, 2);
         gap_max = (ph % 3 == 0) ? 0 : $urandom_range(1, 6);
         for (int k = 0; k < 110; k++) begin
            if (ph == 3 && k == 20) hold_reqs++;
            if (ph == 5 && k == 50) begin
               req_valid <= 1'b0;
               burst_left = 0;
               wait_drained();
            end
            send(rand_req(), 0, '0);
         end
      end

      req_valid <= 1'b0;
      while (pulse_q.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (fails == 0 && pulse_q.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

// ----- servo_angle_to_pulse_slew_top.f -----
hdl/sap_pkg.sv
hdl/servo_angle_to_pulse_slew_top.sv
hdl/sap_check.sv
sim/tb_top.sv
